FILE: rtl/rgbls_pkg.sv
// Shared types and constants of the RGB LED strip frame serializer.
`timescale 1ns / 1ps

package rgbls_pkg;

    localparam int OP_W   = 3;
    localparam int IDX_W  = 10;
    localparam int PCT_W  = 7;
    localparam int CNT_W  = 11;
    localparam int BR_W   = 5;
    localparam int COL_W  = 24;
    localparam int POS_W  = 15;
    localparam int WIDE_W = 17;
    localparam int IN_W   = 48;
    localparam int OUT_W  = 8;

    localparam logic [OP_W-1:0] OP_SET_EN  = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_BR  = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_COL = 3'd2;
    localparam logic [OP_W-1:0] OP_START   = 3'd3;
    localparam logic [OP_W-1:0] OP_PULL    = 3'd4;

    localparam logic REG_LED_COUNT  = 1'b0;
    localparam logic REG_DEFAULT_BR = 1'b1;

    localparam logic [OUT_W-1:0] BYTE_HDR  = 8'hE0;
    localparam logic [OUT_W-1:0] BYTE_END  = 8'hFF;
    localparam logic [OUT_W-1:0] BYTE_ZERO = 8'h00;
    localparam logic [BR_W-1:0]  BR_RESET  = 5'd31;
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_ZERO = 2'd0;
    localparam kind_t KIND_LED  = 2'd1;
    localparam kind_t KIND_END  = 2'd2;

    typedef struct packed {
        kind_t      kind;
        logic [1:0] sub;
        logic       in_range;
        logic       last;
    } pull_t;

endpackage

FILE: rtl/rgb_led_strip_frame_serializer_top.sv
// Top level of the RGB LED strip frame serializer.
//
// Command words enter on the s_ channel; frame bytes leave on the m_ channel,
// with m_tlast on the final end byte of a frame. Configuration is written
// through cfg_we / cfg_index / cfg_data; the user must write it only while
// the block is idle, which the block itself does not enforce.
// Per-LED colour and enable live in one RAM, brightness in a second RAM.
// Set brightness and start frame take effect when accepted. Set enable and
// set colour do a read and then a write back of the colour RAM entry.
// A pull goes through the RAM read, then the output register, before its
// byte is on m_tdata. A pull is held off while an earlier byte waits in the
// output register and m_tready is low; other commands are still taken then.
// After reset both RAMs are swept, one entry a cycle, from the first entry
// to the last, and s_tready stays low. A write of default_brightness starts
// the same sweep over the brightness RAM.
`timescale 1ns / 1ps

module rgb_led_strip_frame_serializer_top #(
    parameter int LED_MAX = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], led_index[12:3], on_flag[13], brightness_pct[20:14],
    // red[28:21], green[36:29], blue[44:37], zero[47:45]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int AW = LED_MAX > 1 ? $clog2(LED_MAX) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(LED_MAX - 1);
    localparam logic [rgbls_pkg::WIDE_W-1:0] LIM = rgbls_pkg::WIDE_W'(LED_MAX);
    localparam int AW_A = rgbls_pkg::COL_W + 1;

    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    function automatic logic [rgbls_pkg::BR_W-1:0] pct_level(
        input logic [rgbls_pkg::PCT_W-1:0] pct
    );
        logic [rgbls_pkg::PCT_W-1:0] p;
        logic [11:0]                 x;
        logic [16:0]                 t;
        logic [rgbls_pkg::BR_W-1:0]  q;
        p = (pct > rgbls_pkg::PCT_FULL) ? rgbls_pkg::PCT_FULL : pct;
        x = 12'(p) * 12'd31;
        t = 17'(x) * 17'd41;
        q = t[16:12];
        if ((12'(q) * 12'd100) > x)
        begin
            q = q - 5'd1;
        end
        return q;
    endfunction

    logic                              state_reg, state_next;
    logic [AW-1:0]                     sweep_reg, sweep_next;
    logic                              clr_col_reg, clr_col_next;
    logic [rgbls_pkg::CNT_W-1:0]       led_count_reg, led_count_next;
    logic [rgbls_pkg::BR_W-1:0]        default_br_reg, default_br_next;
    logic [rgbls_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                              run_reg, run_next;
    logic                              pend_pull_reg, pend_pull_next;
    logic                              pend_rmw_reg, pend_rmw_next;
    logic                              m_tvalid_reg, m_tvalid_next;

    rgbls_pkg::pull_t                  pull_reg, pull_next;
    logic                              rmw_is_en_reg, rmw_is_en_next;
    logic [AW-1:0]                     rmw_addr_reg, rmw_addr_next;
    logic                              rmw_on_reg, rmw_on_next;
    logic [rgbls_pkg::COL_W-1:0]       rmw_col_reg, rmw_col_next;
    logic [7:0]                        m_tdata_reg, m_tdata_next;
    logic                              m_tlast_reg, m_tlast_next;

    logic [rgbls_pkg::OP_W-1:0]        op;
    logic [rgbls_pkg::IDX_W-1:0]       idx;
    logic                              on_flag;
    logic [rgbls_pkg::PCT_W-1:0]       pct;
    logic [7:0]                        red, green, blue;

    logic [rgbls_pkg::WIDE_W-1:0]      cnt_w, n_w, idx_w, led_w;
    logic                              idx_ok;
    logic [rgbls_pkg::POS_W-1:0]       n_p, led_end, tail_len, last_pos, rel;
    rgbls_pkg::pull_t                  pull_calc;
    logic                              accept;

    logic                              a_we;
    logic [AW-1:0]                     a_waddr, a_raddr;
    logic [AW_A-1:0]                   a_wdata, a_rdata;
    logic                              b_we;
    logic [AW-1:0]                     b_waddr;
    logic [rgbls_pkg::BR_W-1:0]        b_wdata, b_rdata;
    logic                              led_on;

    rgbls_ram #(
        .WIDTH (AW_A),
        .DEPTH (LED_MAX)
    ) u_colour_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    rgbls_ram #(
        .WIDTH (rgbls_pkg::BR_W),
        .DEPTH (LED_MAX)
    ) u_bright_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (a_raddr),
        .rdata (b_rdata)
    );

    assign op      = s_tdata[2:0];
    assign idx     = s_tdata[12:3];
    assign on_flag = s_tdata[13];
    assign pct     = s_tdata[20:14];
    assign red     = s_tdata[28:21];
    assign green   = s_tdata[36:29];
    assign blue    = s_tdata[44:37];

    always_comb
    begin
        cnt_w = rgbls_pkg::WIDE_W'(led_count_reg);
        if (cnt_w == '0)
        begin
            n_w = rgbls_pkg::WIDE_W'(1);
        end
        else if (cnt_w > LIM)
        begin
            n_w = LIM;
        end
        else
        begin
            n_w = cnt_w;
        end
        idx_w  = rgbls_pkg::WIDE_W'(idx);
        idx_ok = idx_w < n_w;

        n_p       = n_w[rgbls_pkg::POS_W-1:0];
        led_end   = 15'd4 + (n_p << 2);
        tail_len  = (n_p + 15'd15) >> 4;
        last_pos  = led_end + tail_len - 15'd1;
        rel       = pos_reg - 15'd4;
        led_w     = rgbls_pkg::WIDE_W'(rel >> 2);

        pull_calc.sub      = rel[1:0];
        pull_calc.in_range = led_w < LIM;
        pull_calc.last     = 1'b0;
        if (pos_reg < 15'd4)
        begin
            pull_calc.kind = rgbls_pkg::KIND_ZERO;
        end
        else if (pos_reg < led_end)
        begin
            pull_calc.kind = rgbls_pkg::KIND_LED;
        end
        else
        begin
            pull_calc.kind = rgbls_pkg::KIND_END;
            pull_calc.last = pos_reg >= last_pos;
        end
    end

    assign s_tready = (state_reg == ST_RUN) && !pend_pull_reg && !pend_rmw_reg &&
                      ((op != rgbls_pkg::OP_PULL) || !m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign a_raddr  = (op == rgbls_pkg::OP_PULL) ? led_w[AW-1:0] : idx_w[AW-1:0];
    assign led_on   = pull_reg.in_range && a_rdata[rgbls_pkg::COL_W];

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        clr_col_next    = clr_col_reg;
        led_count_next  = led_count_reg;
        default_br_next = default_br_reg;
        pos_next        = pos_reg;
        run_next        = run_reg;
        pend_pull_next  = 1'b0;
        pend_rmw_next   = 1'b0;
        m_tvalid_next   = m_tvalid_reg;
        pull_next       = pull_reg;
        rmw_is_en_next  = rmw_is_en_reg;
        rmw_addr_next   = rmw_addr_reg;
        rmw_on_next     = rmw_on_reg;
        rmw_col_next    = rmw_col_reg;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;

        a_we    = 1'b0;
        a_waddr = rmw_addr_reg;
        a_wdata = rmw_is_en_reg ? {rmw_on_reg, a_rdata[rgbls_pkg::COL_W-1:0]}
                                : {a_rdata[rgbls_pkg::COL_W], rmw_col_reg};
        b_we    = 1'b0;
        b_waddr = idx_w[AW-1:0];
        b_wdata = pct_level(pct);

        // sweep the RAMs after reset, or the brightness RAM after a default brightness reload
        if (state_reg == ST_CLEAR)
        begin
            a_we    = clr_col_reg;
            a_waddr = sweep_reg;
            a_wdata = '0;
            b_we    = 1'b1;
            b_waddr = sweep_reg;
            b_wdata = default_br_reg;
            if (sweep_reg == LAST_ADDR)
            begin
                state_next   = ST_RUN;
                clr_col_next = 1'b0;
            end
            else
            begin
                sweep_next = sweep_reg + 1'b1;
            end
        end

        if (cfg_we)
        begin
            case (cfg_index)
                rgbls_pkg::REG_LED_COUNT:
                begin
                    led_count_next = cfg_data;
                end
                rgbls_pkg::REG_DEFAULT_BR:
                begin
                    default_br_next = cfg_data[rgbls_pkg::BR_W-1:0];
                    state_next      = ST_CLEAR;
                    sweep_next      = '0;
                end
                default:
                begin
                    led_count_next = led_count_reg;
                end
            endcase
        end

        // write back the colour entry
        if (pend_rmw_reg)
        begin
            a_we = 1'b1;
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (pend_pull_reg)
        begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = pull_reg.last;
            case (pull_reg.kind)
                rgbls_pkg::KIND_LED:
                begin
                    case (pull_reg.sub)
                        2'd0:    m_tdata_next = rgbls_pkg::BYTE_HDR |
                                                (led_on ? 8'(b_rdata) : 8'h00);
                        2'd1:    m_tdata_next = led_on ? a_rdata[7:0] : rgbls_pkg::BYTE_ZERO;
                        2'd2:    m_tdata_next = led_on ? a_rdata[15:8] : rgbls_pkg::BYTE_ZERO;
                        default: m_tdata_next = led_on ? a_rdata[23:16] : rgbls_pkg::BYTE_ZERO;
                    endcase
                end
                rgbls_pkg::KIND_END:
                begin
                    m_tdata_next = rgbls_pkg::BYTE_END;
                end
                default:
                begin
                    m_tdata_next = rgbls_pkg::BYTE_ZERO;
                end
            endcase
        end

        if (accept)
        begin
            case (op)
                rgbls_pkg::OP_SET_EN,
                rgbls_pkg::OP_SET_COL:
                begin
                    if (idx_ok)
                    begin
                        pend_rmw_next  = 1'b1;
                        rmw_is_en_next = op == rgbls_pkg::OP_SET_EN;
                        rmw_addr_next  = idx_w[AW-1:0];
                        rmw_on_next    = on_flag;
                        rmw_col_next   = {red, green, blue};
                    end
                end
                rgbls_pkg::OP_SET_BR:
                begin
                    b_we = idx_ok;
                end
                rgbls_pkg::OP_START:
                begin
                    pos_next = '0;
                    run_next = 1'b1;
                end
                rgbls_pkg::OP_PULL:
                begin
                    if (run_reg)
                    begin
                        pend_pull_next = 1'b1;
                        pull_next      = pull_calc;
                        if (pull_calc.last)
                        begin
                            pos_next = '0;
                            run_next = 1'b0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 15'd1;
                        end
                    end
                end
                default:
                begin
                    run_next = run_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            clr_col_reg    <= 1'b1;
            led_count_reg  <= 11'd1;
            default_br_reg <= rgbls_pkg::BR_RESET;
            pos_reg        <= '0;
            run_reg        <= 1'b0;
            pend_pull_reg  <= 1'b0;
            pend_rmw_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            clr_col_reg    <= clr_col_next;
            led_count_reg  <= led_count_next;
            default_br_reg <= default_br_next;
            pos_reg        <= pos_next;
            run_reg        <= run_next;
            pend_pull_reg  <= pend_pull_next;
            pend_rmw_reg   <= pend_rmw_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pull_reg      <= pull_next;
        rmw_is_en_reg <= rmw_is_en_next;
        rmw_addr_reg  <= rmw_addr_next;
        rmw_on_reg    <= rmw_on_next;
        rmw_col_reg   <= rmw_col_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_pull_reg |-> !m_tvalid_reg)
        else $error("pull byte lands on an occupied output register");

    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_pull_reg && pend_rmw_reg))
        else $error("pull and colour write back pending together");

    a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |-> (pos_reg == '0))
        else $error("frame position nonzero with no frame running");

    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tlast_reg) |-> (m_tdata_reg == rgbls_pkg::BYTE_END))
        else $error("last word is not an end byte");

    a_clear_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!pend_pull_reg && !pend_rmw_reg))
        else $error("command pending during RAM sweep");
`endif

endmodule

FILE: rtl/rgbls_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module rgbls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: dv/rgb_led_strip_frame_serializer_top_tb.sv
// Self-checking testbench for the RGB LED strip frame serializer top level.
`timescale 1ns / 1ps

module rgb_led_strip_frame_serializer_top_tb;

    localparam int LEDS          = 1024;
    localparam int SETTLE        = 8;
    localparam int LIMIT         = 400000;
    localparam int IDLE_PCT      = 9;
    localparam int RANDOM_WORDS  = 230;
    localparam int BR_SCALE      = 31;
    localparam int LEAD_BYTES    = 4;
    localparam int BYTES_PER_LED = 4;
    localparam int END_GROUP     = 16;
    localparam int N_BAD_OPS     = 3;
    localparam int RESET_CYCLES  = 5;
    localparam logic [rgbls_pkg::OP_W-1:0] OP_FIRST_BAD = rgbls_pkg::OP_PULL + 3'd1;

    typedef struct packed {
        logic [rgbls_pkg::OUT_W-1:0] data;
        logic                        last;
    } frame_byte_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [rgbls_pkg::IN_W-1:0]  s_tdata   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [rgbls_pkg::OUT_W-1:0] m_tdata;
    logic                        m_tlast;
    logic                        cfg_we    = 1'b0;
    logic                        cfg_index = rgbls_pkg::REG_LED_COUNT;
    logic [rgbls_pkg::CNT_W-1:0] cfg_data  = '0;

    logic [rgbls_pkg::COL_W-1:0] colour_mem [LEDS];
    logic [rgbls_pkg::BR_W-1:0]  bright_mem [LEDS];
    logic                        lit_mem    [LEDS];
    int unsigned                 frame_pos;
    logic                        frame_on;
    logic [rgbls_pkg::CNT_W-1:0] count_reg;

    logic [rgbls_pkg::IN_W-1:0]  command_q [$];
    frame_byte_t                 frame_byte_q [$];
    frame_byte_t                 want;
    logic                        steady = 1'b0;
    int unsigned                 words_queued  = 0;
    int unsigned                 words_sent    = 0;
    int unsigned                 bytes_seen    = 0;
    int unsigned                 frames_closed = 0;
    int unsigned                 errors        = 0;
    int unsigned                 cycles        = 0;
    logic [rgbls_pkg::OP_W-1:0]  set_ops [3] = '{rgbls_pkg::OP_SET_EN,
                                                 rgbls_pkg::OP_SET_BR,
                                                 rgbls_pkg::OP_SET_COL};

    rgb_led_strip_frame_serializer_top #(.LED_MAX(LEDS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned live_count(input logic [rgbls_pkg::CNT_W-1:0] c);
        if (c == '0)
            return 1;
        if (c > LEDS)
            return LEDS;
        return 32'(c);
    endfunction

    function automatic int unsigned tail_bytes(input int unsigned n);
        int unsigned t;
        t = (n + END_GROUP - 1) / END_GROUP;
        return (t < 1) ? 1 : t;
    endfunction

    function automatic int unsigned frame_len(input int unsigned n);
        return LEAD_BYTES + BYTES_PER_LED * n + tail_bytes(n);
    endfunction

    function automatic logic [rgbls_pkg::IN_W-1:0] pack_word(
        input logic [rgbls_pkg::OP_W-1:0]  op,
        input logic [rgbls_pkg::IDX_W-1:0] idx,
        input logic                        on,
        input logic [rgbls_pkg::PCT_W-1:0] pct,
        input logic [7:0]                  r,
        input logic [7:0]                  g,
        input logic [7:0]                  b);
        return {3'b000, b, g, r, pct, on, idx, op};
    endfunction

    function automatic logic [rgbls_pkg::IN_W-1:0] rand_word(
        input logic [rgbls_pkg::OP_W-1:0]  op,
        input logic [rgbls_pkg::IDX_W-1:0] idx);
        return pack_word(op, idx, 1'($urandom), 7'($urandom_range(0, 127)),
                         8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic logic [rgbls_pkg::IDX_W-1:0] rand_index(input int unsigned n);
        if ($urandom_range(0, 99) < 80)
            return rgbls_pkg::IDX_W'($urandom_range(0, n - 1));
        return rgbls_pkg::IDX_W'($urandom_range(0, LEDS - 1));
    endfunction

    // Advance the strip state by one accepted command word.
    task automatic apply_command(input logic [rgbls_pkg::IN_W-1:0] w);
        logic [rgbls_pkg::OP_W-1:0]  op;
        logic [rgbls_pkg::IDX_W-1:0] idx;
        logic [rgbls_pkg::PCT_W-1:0] pct;
        logic                        ok;
        int unsigned                 n;
        int unsigned                 p;
        int unsigned                 led_end;
        int unsigned                 led;
        int unsigned                 sub;
        frame_byte_t                 fb;
        op  = w[2:0];
        idx = w[12:3];
        pct = w[20:14];
        n   = live_count(count_reg);
        ok  = idx < n;
        case (op)
            rgbls_pkg::OP_SET_EN:
                if (ok)
                    lit_mem[idx] = w[13];
            rgbls_pkg::OP_SET_BR:
                if (ok)
                begin
                    if (pct > rgbls_pkg::PCT_FULL)
                        pct = rgbls_pkg::PCT_FULL;
                    bright_mem[idx] = rgbls_pkg::BR_W'((pct * BR_SCALE) / rgbls_pkg::PCT_FULL);
                end
            rgbls_pkg::OP_SET_COL:
                if (ok)
                    colour_mem[idx] = {w[28:21], w[36:29], w[44:37]};
            rgbls_pkg::OP_START:
            begin
                frame_pos = 0;
                frame_on  = 1'b1;
            end
            rgbls_pkg::OP_PULL:
                if (frame_on)
                begin
                    p       = frame_pos;
                    led_end = LEAD_BYTES + BYTES_PER_LED * n;
                    fb.last = 1'b0;
                    if (p < LEAD_BYTES)
                        fb.data = rgbls_pkg::BYTE_ZERO;
                    else if (p < led_end)
                    begin
                        led = (p - LEAD_BYTES) / BYTES_PER_LED;
                        sub = (p - LEAD_BYTES) % BYTES_PER_LED;
                        if (sub == 0)
                            fb.data = lit_mem[led] ?
                                      (rgbls_pkg::BYTE_HDR | bright_mem[led]) :
                                      rgbls_pkg::BYTE_HDR;
                        else if (!lit_mem[led])
                            fb.data = rgbls_pkg::BYTE_ZERO;
                        else
                            fb.data = colour_mem[led][8 * (sub - 1) +: 8];
                    end
                    else
                    begin
                        fb.data = rgbls_pkg::BYTE_END;
                        fb.last = (p - led_end) >= tail_bytes(n) - 1;
                    end
                    if (fb.last)
                    begin
                        frame_on  = 1'b0;
                        frame_pos = 0;
                        frames_closed++;
                    end
                    else
                        frame_pos = p + 1;
                    frame_byte_q.push_back(fb);
                end
            default: ;
        endcase
    endtask

    task automatic push_word(input logic [rgbls_pkg::IN_W-1:0] w);
        command_q.push_back(w);
        words_queued++;
    endtask

    task automatic push_set(input int unsigned n);
        push_word(rand_word(set_ops[$urandom_range(0, 2)], rand_index(n)));
    endtask

    task automatic push_noise(input int unsigned n);
        case ($urandom_range(0, 2))
            0: push_word(rand_word(OP_FIRST_BAD +
                                   rgbls_pkg::OP_W'($urandom_range(0, N_BAD_OPS - 1)),
                                   rand_index(n)));
            1: push_word(rand_word(rgbls_pkg::OP_PULL, rand_index(n)));
            default: push_set(n);
        endcase
    endtask

    // Queue a frame: a few edits, the start, then pulls with edits and rare restarts.
    task automatic push_frame(input int unsigned n, input int unsigned cut);
        int unsigned len;
        len = frame_len(n);
        if (cut != 0 && cut < len)
            len = cut;
        repeat ($urandom_range(0, 5))
            push_set(n);
        push_word(rand_word(rgbls_pkg::OP_START, rand_index(n)));
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 12)
                push_set(n);
            if ($urandom_range(0, 99) < 2)
                push_word(rand_word(rgbls_pkg::OP_START, rand_index(n)));
            push_word(rand_word(rgbls_pkg::OP_PULL, rand_index(n)));
        end
    endtask

    task automatic write_reg(input logic idx, input logic [rgbls_pkg::CNT_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == rgbls_pkg::REG_LED_COUNT)
            count_reg = val;
        else
            for (int i = 0; i < LEDS; i++)
                bright_mem[i] = val[rgbls_pkg::BR_W-1:0];
    endtask

    // Hold until every queued word is taken and every byte is back.
    task automatic settle();
        while (command_q.size() != 0 || s_tvalid || frame_byte_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_command(s_tdata);
                words_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (command_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= command_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                bytes_seen++;
                if (frame_byte_q.size() == 0)
                begin
                    $error("frame_byte unexpected: got %02h last %0b", m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    want = frame_byte_q.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $error("frame_byte expected %02h got %02h", want.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_byte expected %0b got %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned                 base;
        int unsigned                 n;
        logic [rgbls_pkg::CNT_W-1:0] c;
        int unsigned                 r;
        for (int i = 0; i < LEDS; i++)
        begin
            colour_mem[i] = '0;
            bright_mem[i] = rgbls_pkg::BR_RESET;
            lit_mem[i]    = 1'b0;
        end
        frame_pos = 0;
        frame_on  = 1'b0;
        count_reg = rgbls_pkg::CNT_W'(1);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // Edge cases at reset configuration: a single LED.
        push_word(rand_word(rgbls_pkg::OP_PULL, '0));
        push_word(rand_word(OP_FIRST_BAD, '0));
        push_word(rand_word(OP_FIRST_BAD + rgbls_pkg::OP_W'(N_BAD_OPS - 1), '1));
        push_word(pack_word(rgbls_pkg::OP_SET_EN, '0, 1'b1, '0, '0, '0, '0));
        push_word(pack_word(rgbls_pkg::OP_SET_EN, rgbls_pkg::IDX_W'(LEDS - 1), 1'b1,
                            '1, '1, '1, '1));
        push_word(pack_word(rgbls_pkg::OP_SET_BR, '0, 1'b0, '1, '0, '0, '0));
        push_word(pack_word(rgbls_pkg::OP_SET_COL, '0, 1'b0, '0, 8'hFF, 8'h00, 8'hAA));
        push_word(pack_word(rgbls_pkg::OP_SET_COL, rgbls_pkg::IDX_W'(1), 1'b1, '0,
                            8'h11, 8'h22, 8'h33));
        push_word(rand_word(rgbls_pkg::OP_START, '0));
        repeat (2) push_word(rand_word(rgbls_pkg::OP_PULL, '0));
        push_word(rand_word(rgbls_pkg::OP_START, '0));
        repeat (LEAD_BYTES + 1) push_word(rand_word(rgbls_pkg::OP_PULL, '0));
        push_word(pack_word(rgbls_pkg::OP_SET_BR, '0, 1'b0, '0, '0, '0, '0));
        push_word(pack_word(rgbls_pkg::OP_SET_COL, '0, 1'b0, '0, 8'h00, 8'hFF, 8'h55));
        repeat (BYTES_PER_LED) push_word(rand_word(rgbls_pkg::OP_PULL, '0));
        push_word(rand_word(rgbls_pkg::OP_PULL, '0));
        settle();

        write_reg(rgbls_pkg::REG_LED_COUNT, '0);
        write_reg(rgbls_pkg::REG_DEFAULT_BR, '0);
        push_frame(1, 0);
        settle();

        // Largest strip, opening bytes only, no idling on either side.
        steady = 1'b1;
        write_reg(rgbls_pkg::REG_LED_COUNT, rgbls_pkg::CNT_W'(LEDS));
        write_reg(rgbls_pkg::REG_DEFAULT_BR, '1);
        push_word(pack_word(rgbls_pkg::OP_SET_EN, rgbls_pkg::IDX_W'(LEDS - 1), 1'b1,
                            '0, '0, '0, '0));
        push_word(rand_word(rgbls_pkg::OP_SET_COL, rgbls_pkg::IDX_W'(LEDS - 1)));
        push_word(pack_word(rgbls_pkg::OP_SET_BR, rgbls_pkg::IDX_W'(LEDS - 1), 1'b0,
                            rgbls_pkg::PCT_FULL, '0, '0, '0));
        push_frame(LEDS, 120);
        settle();
        steady = 1'b0;

        // Oversized count, then shrink it under a running frame.
        write_reg(rgbls_pkg::REG_LED_COUNT, '1);
        push_word(rand_word(rgbls_pkg::OP_SET_COL, rgbls_pkg::IDX_W'(LEDS - 1)));
        push_frame(LEDS, 40);
        settle();
        write_reg(rgbls_pkg::REG_LED_COUNT, rgbls_pkg::CNT_W'(3));
        push_word(rand_word(rgbls_pkg::OP_PULL, '0));
        push_frame(3, 0);
        settle();

        base = words_queued;
        while (words_queued - base < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                c = '0;
            else if (r < 14)
                c = rgbls_pkg::CNT_W'($urandom_range(LEDS + 1, 2047));
            else if (r < 20)
                c = rgbls_pkg::CNT_W'(END_GROUP + $urandom_range(0, 1));
            else
                c = rgbls_pkg::CNT_W'($urandom_range(1, 24));
            write_reg(rgbls_pkg::REG_LED_COUNT, c);
            if ($urandom_range(0, 1) == 1)
                write_reg(rgbls_pkg::REG_DEFAULT_BR, rgbls_pkg::CNT_W'($urandom));
            n = live_count(c);
            repeat ($urandom_range(1, 3))
            begin
                push_noise(n);
                if (n > 64)
                    push_frame(n, $urandom_range(4, 60));
                else if ($urandom_range(0, 99) < 20)
                    push_frame(n, $urandom_range(1, frame_len(n)));
                else
                    push_frame(n, 0);
            end
            settle();
        end

        repeat (SETTLE) @(posedge clk);
        $display("Drove %0d command words; %0d frame bytes compared over %0d finished frames.",
                 words_sent, bytes_seen, frames_closed);
        $display("Strip lengths 0 to 2047, brightness reloads and mid-frame edits included.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
